// ----- rtl/core/bpa_pkg.sv -----
// Package: constants, codes and types shared by the buddy page allocator.
package bpa_pkg;

  localparam int unsigned MaxPoolPages = 32768;
  localparam int unsigned TopRank      = 16;
  localparam int unsigned PageW        = 15;
  localparam int unsigned RankW        = 5;
  localparam int unsigned TagW         = 7;
  localparam int unsigned CountW       = 16;
  localparam int unsigned CntIdxW      = 4;

  localparam logic [TagW-1:0] TAG_START = 7'h20;
  localparam logic [TagW-1:0] TAG_ALLOC = 7'h40;

  typedef enum logic [2:0] {
    FN_INIT  = 3'd0,
    FN_ALLOC = 3'd1,
    FN_FREE  = 3'd2,
    FN_QRANK = 3'd3,
    FN_COUNT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_NOSPC = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_LAY_PICK,
    S_LAY_MARK,
    S_AL_RANK,
    S_AL_SCAN,
    S_AL_SCANW,
    S_AL_SPLIT,
    S_AL_MARK,
    S_FR_RD,
    S_FR_RDW,
    S_FR_CHK,
    S_FR_BRD,
    S_FR_BRDW,
    S_FR_BCHK,
    S_FR_MARK,
    S_QR_RD,
    S_QR_RDW,
    S_CNT_RD,
    S_CNT_RDW,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/bpa_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// Top level: buddy page allocator over a tag memory and per-rank free counts.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------
//  request | in_func, in_page_index, in_req_rank     | start & !busy
//  result  | out_status, out_block_page, out_value   | out_valid, one cycle
//  config  | cfg_data                                | cfg_valid & cfg_ready
//
// One request at a time; busy drops in the cycle of the result strobe.
// A count answer passes S_CNT_RD and S_DONE, a rank query S_QR_RD, S_QR_RDW
// and S_DONE. Init (and the reset layout) clears all 32768 tags one per cycle,
// then marks the pool one page per cycle, with a pick step before each block.
// Allocate scans the tag RAM, one page per S_AL_SCAN/S_AL_SCANW pair, until it
// finds the lowest free block start, then rewrites one page per cycle; free
// uses S_FR_CHK and S_FR_BRD per merge step, then rewrites the merged block
// one page per cycle. After reset the block runs the layout pass before
// taking a request. The receiver cannot stall; results are never held.
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic [PageW-1:0]    in_page_index,
  input  logic [RankW-1:0]    in_req_rank,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [PageW-1:0]    out_block_page,
  output logic [CountW-1:0]   out_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int unsigned AW = $clog2(MaxPoolPages);

  state_t state_r, state_nxt;

  // register, request and work registers
  logic [15:0]        pool_pages_r;
  logic [16:0]        pool_use_r, pool_use_nxt;
  logic [PageW-1:0]   page_r, page_nxt;
  logic [RankW-1:0]   rank_r, rank_nxt;
  logic [RankW-1:0]   ar_r, ar_nxt;          // working rank
  logic [16:0]        idx_r, idx_nxt;        // working page / cursor
  logic [16:0]        ptr_r, ptr_nxt;        // sweep pointer
  logic [16:0]        end_r, end_nxt;        // sweep end (exclusive)
  logic [TagW-1:0]    mtag_r, mtag_nxt;      // tag of block start while marking
  logic               init_req_r, init_req_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [PageW-1:0]   bp_r, bp_nxt;
  logic [CountW-1:0]  val_r, val_nxt;
  logic               ov_r, ov_nxt;
  logic [CountW-1:0]  fc_r [TopRank];     // per-rank free counts (fixed lanes)
  logic [CountW-1:0]  fc_nxt [TopRank];

  // tag memory
  logic             t_we;
  logic [AW-1:0]    t_waddr, t_raddr;
  logic [TagW-1:0]  t_wdata, t_rdata;

  bpa_ram #(.Width(TagW), .Depth(MaxPoolPages)) u_tag (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_block_page = bp_r;
  assign out_value      = val_r;

  function automatic logic [16:0] bsize(input logic [RankW-1:0] r);
    bsize = 17'd1 << (r - 5'd1);
  endfunction

  // largest aligned rank that fits at i within n
  function automatic logic [RankW-1:0] fit_rank(input logic [16:0] i, input logic [16:0] n);
    logic [RankW-1:0] r;
    r = 5'd1;
    for (int k = 2; k <= TopRank; k++) begin
      if (((i & ((17'd1 << (k - 1)) - 17'd1)) == 17'd0) &&
          ((i + (17'd1 << (k - 1))) <= n)) begin
        r = RankW'(k);
      end
    end
    fit_rank = r;
  endfunction

  logic rank_ok;
  assign rank_ok = (rank_r >= 5'd1) && (rank_r <= RankW'(TopRank));

  logic [RankW-1:0] tr;
  assign tr = t_rdata[RankW-1:0];

  // rank of the next block laid out at the cursor
  logic [RankW-1:0] lay_rank;
  assign lay_rank = fit_rank(idx_r, pool_use_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      pool_pages_r <= 16'd32768;
      pool_use_r   <= 17'(MaxPoolPages);
      ptr_r        <= '0;
      end_r        <= 17'(MaxPoolPages);
      init_req_r   <= 1'b0;
      ov_r         <= 1'b0;
      for (int i = 0; i < TopRank; i++) fc_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      pool_use_r <= pool_use_nxt;
      ptr_r      <= ptr_nxt;
      end_r      <= end_nxt;
      init_req_r <= init_req_nxt;
      ov_r       <= ov_nxt;
      for (int i = 0; i < TopRank; i++) fc_r[i] <= fc_nxt[i];
      if (cfg_valid && cfg_ready) begin
        pool_pages_r <= cfg_data;
      end
    end
    page_r <= page_nxt;
    rank_r <= rank_nxt;
    ar_r   <= ar_nxt;
    idx_r  <= idx_nxt;
    mtag_r <= mtag_nxt;
    st_r   <= st_nxt;
    bp_r   <= bp_nxt;
    val_r  <= val_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    pool_use_nxt = pool_use_r;
    page_nxt     = page_r;
    rank_nxt     = rank_r;
    ar_nxt       = ar_r;
    idx_nxt      = idx_r;
    ptr_nxt      = ptr_r;
    end_nxt      = end_r;
    mtag_nxt     = mtag_r;
    init_req_nxt = init_req_r;
    st_nxt       = st_r;
    bp_nxt       = bp_r;
    val_nxt      = val_r;
    ov_nxt       = 1'b0;
    for (int i = 0; i < TopRank; i++) fc_nxt[i] = fc_r[i];
    t_we    = 1'b0;
    t_waddr = ptr_r[AW-1:0];
    t_wdata = '0;
    t_raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          page_nxt = in_page_index;
          rank_nxt = in_req_rank;
          st_nxt   = ST_INVAL;
          bp_nxt   = '0;
          val_nxt  = '0;
          case (in_func)
            FN_INIT: begin
              if (pool_pages_r >= 16'd1 && 17'(pool_pages_r) <= 17'(MaxPoolPages)) begin
                pool_use_nxt = 17'(pool_pages_r);
                ptr_nxt      = '0;
                end_nxt      = 17'(MaxPoolPages);
                init_req_nxt = 1'b1;
                state_nxt    = S_CLR;
              end else begin
                state_nxt = S_DONE;
              end
            end
            FN_ALLOC: begin
              ar_nxt    = in_req_rank;
              state_nxt = S_AL_RANK;
            end
            FN_FREE:  state_nxt = S_FR_RD;
            FN_QRANK: state_nxt = S_QR_RD;
            FN_COUNT: state_nxt = S_CNT_RD;
            default:  state_nxt = S_DONE;
          endcase
        end
      end

      // clear every tag, then lay out the pool
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = ptr_r[AW-1:0];
        t_wdata = '0;
        ptr_nxt = ptr_r + 17'd1;
        if (ptr_r == end_r - 17'd1) begin
          for (int i = 0; i < TopRank; i++) fc_nxt[i] = '0;
          idx_nxt   = '0;
          state_nxt = S_LAY_PICK;
        end
      end

      S_LAY_PICK: begin
        if (idx_r >= pool_use_r) begin
          if (init_req_r) begin
            init_req_nxt = 1'b0;
            st_nxt       = ST_OK;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          ar_nxt = lay_rank;
          fc_nxt[lay_rank[CntIdxW-1:0] - 4'd1] = fc_r[lay_rank[CntIdxW-1:0] - 4'd1] + 16'd1;
          ptr_nxt   = idx_r;
          end_nxt   = idx_r + bsize(lay_rank);
          mtag_nxt  = {2'b01, lay_rank};
          state_nxt = S_LAY_MARK;
        end
      end

      // write one block's tags: start tag at ptr==block start, body tags after
      S_LAY_MARK, S_AL_MARK, S_FR_MARK: begin
        t_we    = (ptr_r < pool_use_r);
        t_waddr = ptr_r[AW-1:0];
        t_wdata = mtag_r;
        mtag_nxt = mtag_r & ~TAG_START;
        ptr_nxt  = ptr_r + 17'd1;
        if (ptr_r + 17'd1 >= end_r) begin
          if (state_r == S_LAY_MARK) begin
            idx_nxt   = end_r;
            state_nxt = S_LAY_PICK;
          end else if (state_r == S_AL_SPLIT || state_r == S_AL_MARK) begin
            if (ar_r > rank_r) begin
              state_nxt = S_AL_SPLIT;
            end else begin
              st_nxt    = ST_OK;
              state_nxt = S_DONE;
            end
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end
        end
      end

      // find the smallest rank at or above the requested one with a free block
      S_AL_RANK: begin
        if (!rank_ok) begin
          state_nxt = S_DONE;
        end else if (ar_r > RankW'(TopRank)) begin
          st_nxt    = ST_NOSPC;
          state_nxt = S_DONE;
        end else if (fc_r[ar_r[CntIdxW-1:0] - 4'd1] == '0) begin
          ar_nxt = ar_r + 5'd1;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_AL_SCAN;
        end
      end

      S_AL_SCAN: begin
        if (idx_r >= pool_use_r) begin
          st_nxt    = ST_NOSPC;
          state_nxt = S_DONE;
        end else begin
          t_raddr   = idx_r[AW-1:0];
          state_nxt = S_AL_SCANW;
        end
      end

      S_AL_SCANW: begin
        if (t_rdata[5] && !t_rdata[6] && tr == ar_r) begin
          fc_nxt[ar_r[CntIdxW-1:0] - 4'd1] = fc_r[ar_r[CntIdxW-1:0] - 4'd1] - 16'd1;
          bp_nxt = idx_r[PageW-1:0];
          if (ar_r > rank_r) begin
            state_nxt = S_AL_SPLIT;
          end else begin
            ptr_nxt   = idx_r;
            end_nxt   = idx_r + bsize(rank_r);
            mtag_nxt  = {2'b11, rank_r};
            state_nxt = S_AL_MARK;
          end
        end else begin
          idx_nxt   = idx_r + 17'd1;
          state_nxt = S_AL_SCAN;
        end
      end

      // free the upper half at the next lower rank
      S_AL_SPLIT: begin
        if (ar_r > rank_r) begin
          ar_nxt = ar_r - 5'd1;
          fc_nxt[ar_r[CntIdxW-1:0] - 4'd2] = fc_r[ar_r[CntIdxW-1:0] - 4'd2] + 16'd1;
          ptr_nxt   = idx_r + bsize(ar_r - 5'd1);
          end_nxt   = idx_r + bsize(ar_r);
          mtag_nxt  = {2'b01, ar_r - 5'd1};
          state_nxt = S_FR_BRDW;   // marks the freed upper half
        end
      end

      S_FR_RD: begin
        if (17'(page_r) >= pool_use_r) begin
          state_nxt = S_DONE;
        end else begin
          t_raddr   = page_r;
          state_nxt = S_FR_RDW;
        end
      end

      S_FR_RDW: begin
        if (t_rdata[6] && t_rdata[5]) begin
          ar_nxt    = tr;
          idx_nxt   = 17'(page_r);
          state_nxt = S_FR_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FR_CHK: begin
        if (ar_r < RankW'(TopRank) &&
            ((idx_r ^ bsize(ar_r)) < pool_use_r)) begin
          t_raddr   = idx_r[AW-1:0] ^ bsize(ar_r)[AW-1:0];
          state_nxt = S_FR_BRD;
        end else begin
          state_nxt = S_FR_BCHK;
        end
      end

      S_FR_BRD: begin
        if (t_rdata[5] && !t_rdata[6] && tr == ar_r) begin
          fc_nxt[ar_r[CntIdxW-1:0] - 4'd1] = fc_r[ar_r[CntIdxW-1:0] - 4'd1] - 16'd1;
          idx_nxt   = idx_r & ~bsize(ar_r);
          ar_nxt    = ar_r + 5'd1;
          state_nxt = S_FR_CHK;
        end else begin
          state_nxt = S_FR_BCHK;
        end
      end

      // split marking (allocate) runs here: write upper half tags
      S_FR_BRDW: begin
        t_we     = (ptr_r < pool_use_r);
        t_waddr  = ptr_r[AW-1:0];
        t_wdata  = mtag_r;
        mtag_nxt = mtag_r & ~TAG_START;
        ptr_nxt  = ptr_r + 17'd1;
        if (ptr_r + 17'd1 >= end_r) begin
          if (ar_r > rank_r) begin
            state_nxt = S_AL_SPLIT;
          end else begin
            ptr_nxt   = idx_r;
            end_nxt   = idx_r + bsize(rank_r);
            mtag_nxt  = {2'b11, rank_r};
            state_nxt = S_AL_MARK;
          end
        end
      end

      // merge finished: mark the merged block free
      S_FR_BCHK: begin
        fc_nxt[ar_r[CntIdxW-1:0] - 4'd1] = fc_r[ar_r[CntIdxW-1:0] - 4'd1] + 16'd1;
        ptr_nxt   = idx_r;
        end_nxt   = idx_r + bsize(ar_r);
        mtag_nxt  = {2'b01, ar_r};
        state_nxt = S_FR_MARK;
      end

      S_QR_RD: begin
        if (17'(page_r) >= pool_use_r) begin
          state_nxt = S_DONE;
        end else begin
          t_raddr   = page_r;
          state_nxt = S_QR_RDW;
        end
      end

      S_QR_RDW: begin
        val_nxt   = 16'(tr);
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end

      S_CNT_RD: begin
        if (rank_ok) begin
          val_nxt = fc_r[rank_r[CntIdxW-1:0] - 4'd1];
          st_nxt  = ST_OK;
        end
        state_nxt = S_DONE;
      end

      S_CNT_RDW: state_nxt = S_DONE;

      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // a result strobe only follows the done step
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE)) else $error("stray result");
  // never busy-free while a result is being formed
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> busy) else $error("done while idle");
  // request accepted leaves idle
  a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request dropped");
  // tag writes outside the clear stay inside the pool
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    (t_we && state_r != S_CLR) |-> (ptr_r < pool_use_r)) else $error("tag write out of pool");
`endif

endmodule
